// File: sv/quantizing_record_packer_unit_defines.svh
// ----------------------------------------------------------------------------
// Quantizing record packer assertion macros
// Assertion helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef QUANTIZING_RECORD_PACKER_UNIT_DEFINES_SVH
`define QUANTIZING_RECORD_PACKER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QRP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QRP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define QRP_ASSERT(label, clk, rst_n, prop, msg)
`define QRP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/qrp_pkg.sv
// ----------------------------------------------------------------------------
// Quantizing record packer package
// Shared types and codes.
// ----------------------------------------------------------------------------
package qrp_pkg;
  localparam int CODE_W = 16;

  localparam logic [3:0] OP_ID    = 4'd0;
  localparam logic [3:0] OP_HOST  = 4'd1;
  localparam logic [3:0] OP_COUNT = 4'd2;
  localparam logic [3:0] OP_FLAGS = 4'd3;
  localparam logic [3:0] OP_PRIO  = 4'd4;
  localparam logic [3:0] OP_SEQ   = 4'd5;
  localparam logic [3:0] OP_POS_X = 4'd6;
  localparam logic [3:0] OP_POS_Y = 4'd7;
  localparam logic [3:0] OP_POS_Z = 4'd8;
  localparam logic [3:0] OP_SCL_X = 4'd9;
  localparam logic [3:0] OP_SCL_Y = 4'd10;
  localparam logic [3:0] OP_SCL_Z = 4'd11;
  localparam logic [3:0] OP_OPAC  = 4'd12;
  localparam logic [3:0] OP_UNC   = 4'd13;
  localparam logic [3:0] OP_COEF  = 4'd14;
  localparam logic [3:0] OP_NONE  = 4'd15;

  localparam logic [7:0] REG_MIN_X  = 8'd0;
  localparam logic [7:0] REG_MIN_Y  = 8'd1;
  localparam logic [7:0] REG_MIN_Z  = 8'd2;
  localparam logic [7:0] REG_MAX_X  = 8'd3;
  localparam logic [7:0] REG_MAX_Y  = 8'd4;
  localparam logic [7:0] REG_MAX_Z  = 8'd5;
  localparam logic [7:0] REG_SCALE  = 8'd6;
  localparam logic [7:0] REG_WIDTHS = 8'd7;

  typedef enum logic [1:0] {SEL_RAW, SEL_ZERO, SEL_MAX, SEL_DIV} sel_t;

  typedef struct packed {
    logic [63:0]       raw;
    logic [3:0]        nbytes;
    sel_t              sel;
    logic [CODE_W-1:0] maxcode;
  } side_t;

  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
    logic [30:0] scale_upper;
    logic [14:0] widths;
  } cfg_t;
endpackage

// File: sv/qrp_front.sv
// ----------------------------------------------------------------------------
// Quantizing record packer front end
// Decode, offset and range, clamp decision, numerator product.
// ----------------------------------------------------------------------------
module qrp_front #(
  parameter int MAX_QUANT_BITS = 16,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [3:0]           in_op,
  input  logic [63:0]          in_raw,
  input  logic [31:0]          in_sample,
  input  qrp_pkg::cfg_t        cfg,
  output logic                 out_valid,
  output qrp_pkg::side_t       out_side,
  output logic [49:0]          out_num,
  output logic [32:0]          out_den
);
  localparam logic [32:0] FIX1 = 33'(64'sd1 << FRACTION_BITS);
  localparam logic [32:0] FIX4 = 33'(64'sd4 << FRACTION_BITS);

  logic [32:0]    lo_c;
  logic [32:0]    hi_c;
  logic [4:0]     bits_c;
  logic           fix255_c;
  logic           israw_c;
  logic           bad_c;
  logic [3:0]     nb_c;
  qrp_pkg::side_t side_c;

  always_comb begin
    lo_c     = '0;
    hi_c     = FIX1;
    bits_c   = '0;
    fix255_c = 1'b0;
    israw_c  = 1'b0;
    nb_c     = 4'd2;
    case (in_op)
      qrp_pkg::OP_ID, qrp_pkg::OP_PRIO, qrp_pkg::OP_SEQ: begin
        israw_c = 1'b1;
        nb_c    = 4'd4;
      end
      qrp_pkg::OP_HOST: begin
        israw_c = 1'b1;
        nb_c    = 4'd8;
      end
      qrp_pkg::OP_COUNT, qrp_pkg::OP_FLAGS: begin
        israw_c = 1'b1;
      end
      qrp_pkg::OP_POS_X: begin
        lo_c   = {cfg.min_x[31], cfg.min_x};
        hi_c   = {cfg.max_x[31], cfg.max_x};
        bits_c = cfg.widths[4:0];
      end
      qrp_pkg::OP_POS_Y: begin
        lo_c   = {cfg.min_y[31], cfg.min_y};
        hi_c   = {cfg.max_y[31], cfg.max_y};
        bits_c = cfg.widths[4:0];
      end
      qrp_pkg::OP_POS_Z: begin
        lo_c   = {cfg.min_z[31], cfg.min_z};
        hi_c   = {cfg.max_z[31], cfg.max_z};
        bits_c = cfg.widths[4:0];
      end
      qrp_pkg::OP_SCL_X, qrp_pkg::OP_SCL_Y, qrp_pkg::OP_SCL_Z: begin
        hi_c   = {2'b00, cfg.scale_upper};
        bits_c = cfg.widths[9:5];
      end
      qrp_pkg::OP_OPAC: begin
        fix255_c = 1'b1;
        nb_c     = 4'd1;
      end
      qrp_pkg::OP_UNC: begin
        bits_c = cfg.widths[14:10];
      end
      qrp_pkg::OP_COEF: begin
        lo_c     = 33'd0 - FIX4;
        hi_c     = FIX4;
        fix255_c = 1'b1;
        nb_c     = 4'd1;
      end
      default: begin
        israw_c = 1'b1;
      end
    endcase
    bad_c = !fix255_c && ((bits_c == 5'd0) || (bits_c > 5'(MAX_QUANT_BITS)));
    side_c.raw     = in_raw;
    side_c.nbytes  = nb_c;
    side_c.maxcode = fix255_c ? qrp_pkg::CODE_W'(8'hff)
                              : qrp_pkg::CODE_W'((17'd1 << bits_c) - 17'd1);
    if (israw_c) begin
      side_c.sel = qrp_pkg::SEL_RAW;
    end else if (bad_c) begin
      side_c.sel = qrp_pkg::SEL_ZERO;
    end else begin
      side_c.sel = qrp_pkg::SEL_DIV;
    end
  end

  // stage a: decoded operands
  logic           a_vld_r;
  qrp_pkg::side_t a_side_r;
  logic [32:0]    a_v_r;
  logic [32:0]    a_lo_r;
  logic [32:0]    a_hi_r;
  // stage b: offset and range
  logic           b_vld_r;
  qrp_pkg::side_t b_side_r;
  logic [33:0]    b_d_r;
  logic [33:0]    b_rng_r;
  // stage c: clamp decision
  logic           c_vld_r;
  qrp_pkg::side_t c_side_r;
  logic [31:0]    c_d_r;
  logic [31:0]    c_rng_r;
  // stage d: numerator and divisor
  logic           d_vld_r;
  qrp_pkg::side_t d_side_r;
  logic [49:0]    d_num_r;
  logic [32:0]    d_den_r;

  logic [33:0]    rfix_c;
  qrp_pkg::side_t c_side_nxt;
  logic [47:0]    prod_c;

  always_comb begin
    rfix_c = $signed(b_rng_r) <= 34'sd0 ? {1'b0, FIX1} : b_rng_r;
    c_side_nxt = b_side_r;
    if (b_side_r.sel == qrp_pkg::SEL_DIV) begin
      if ($signed(b_d_r) <= 34'sd0) begin
        c_side_nxt.sel = qrp_pkg::SEL_ZERO;
      end else if ($signed(b_d_r) >= $signed(rfix_c)) begin
        c_side_nxt.sel = qrp_pkg::SEL_MAX;
      end
    end
    prod_c = c_d_r * c_side_r.maxcode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r <= side_c;
      a_v_r    <= {in_sample[31], in_sample};
      a_lo_r   <= lo_c;
      a_hi_r   <= hi_c;
      b_side_r <= a_side_r;
      b_d_r    <= {a_v_r[32], a_v_r} - {a_lo_r[32], a_lo_r};
      b_rng_r  <= {a_hi_r[32], a_hi_r} - {a_lo_r[32], a_lo_r};
      c_side_r <= c_side_nxt;
      c_d_r    <= b_d_r[31:0];
      c_rng_r  <= rfix_c[31:0];
      d_side_r <= c_side_r;
      d_num_r  <= 50'({prod_c, 1'b0}) + 50'(c_rng_r);
      d_den_r  <= {c_rng_r, 1'b0};
    end
  end

  assign out_valid = d_vld_r;
  assign out_side  = d_side_r;
  assign out_num   = d_num_r;
  assign out_den   = d_den_r;
endmodule

// File: sv/qrp_div.sv
// ----------------------------------------------------------------------------
// Quantizing record packer divider
// Restoring division, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module qrp_div #(
  parameter int QB = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  qrp_pkg::side_t in_side,
  input  logic [49:0]    in_num,
  input  logic [32:0]    in_den,
  output logic           out_valid,
  output qrp_pkg::side_t out_side,
  output logic [QB-1:0]  out_q
);
  logic           v_r    [QB];
  qrp_pkg::side_t side_r [QB];
  logic [49:0]    rem_r  [QB];
  logic [32:0]    den_r  [QB];
  logic [QB-1:0]  q_r    [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic           pv;
    qrp_pkg::side_t pside;
    logic [49:0]    prem;
    logic [32:0]    pden;
    logic [QB-1:0]  pq;
    logic [49:0]    shd;
    logic           ge;
    logic [49:0]    rem_nxt;
    logic [QB-1:0]  q_nxt;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign pside = in_side;
      assign prem  = in_num;
      assign pden  = in_den;
      assign pq    = '0;
    end else begin : g_next
      assign pv    = v_r[i-1];
      assign pside = side_r[i-1];
      assign prem  = rem_r[i-1];
      assign pden  = den_r[i-1];
      assign pq    = q_r[i-1];
    end

    always_comb begin
      shd     = 50'(pden) << (QB - 1 - i);
      ge      = prem >= shd;
      rem_nxt = ge ? prem - shd : prem;
      q_nxt   = ge ? (pq | (QB'(1) << (QB - 1 - i))) : pq;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[i] <= pside;
        rem_r[i]  <= rem_nxt;
        den_r[i]  <= pden;
        q_r[i]    <= q_nxt;
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_side  = side_r[QB-1];
  assign out_q     = q_r[QB-1];
endmodule

// File: sv/qrp_ser.sv
// ----------------------------------------------------------------------------
// Quantizing record packer serializer
// Sends a field's bytes, least significant first.
// ----------------------------------------------------------------------------
module qrp_ser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [63:0] in_value,
  input  logic [3:0]  in_nbytes,
  output logic        take,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);
  logic [63:0] val_r;
  logic [3:0]  cnt_r;

  assign out_tvalid = cnt_r != 4'd0;
  assign out_tlast  = cnt_r == 4'd1;
  assign out_tdata  = val_r[7:0];
  assign take       = !out_tvalid || (out_tlast && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else if (take) begin
      cnt_r <= in_valid ? in_nbytes : 4'd0;
    end else if (out_tready) begin
      cnt_r <= cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      val_r <= in_value;
    end else if (out_tready) begin
      val_r <= {8'd0, val_r[63:8]};
    end
  end
endmodule

// File: sv/quantizing_record_packer_unit.sv
// Throughput: one byte per cycle on out_ while out_tready is high; input stalls
// while the last stage waits on the serializer.
// Quantized fields are 1 or 2 bytes long, raw fields 2 to 8 bytes, sent on the one-byte output port.
// Reset: synchronous active-low rst_n empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// Quantizing record packer
// Min-max quantizes or passes point record fields and emits their bytes.
// ----------------------------------------------------------------------------
`include "quantizing_record_packer_unit_defines.svh"

module quantizing_record_packer_unit #(
  parameter int MAX_QUANT_BITS = 16,
  parameter int FRACTION_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // raw_value[63:0], sample_value[95:64]
  input  logic [3:0]  in_tuser,   // operation[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int QB = (MAX_QUANT_BITS > 8) ? MAX_QUANT_BITS : 8;
  localparam logic [31:0] FIX1 = 32'(64'sd1 << FRACTION_BITS);

  qrp_pkg::cfg_t  cfg_r;
  logic           adv;
  logic           take;
  logic           f_valid;
  qrp_pkg::side_t f_side;
  logic [49:0]    f_num;
  logic [32:0]    f_den;
  logic           div_valid;
  qrp_pkg::side_t div_side;
  logic [QB-1:0]  div_q;
  logic [63:0]    value_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_x       <= '0;
      cfg_r.min_y       <= '0;
      cfg_r.min_z       <= '0;
      cfg_r.max_x       <= FIX1;
      cfg_r.max_y       <= FIX1;
      cfg_r.max_z       <= FIX1;
      cfg_r.scale_upper <= FIX1[30:0];
      cfg_r.widths      <= 15'd12816;
    end else if (cfg_valid) begin
      case (cfg_index)
        qrp_pkg::REG_MIN_X:  cfg_r.min_x       <= cfg_data;
        qrp_pkg::REG_MIN_Y:  cfg_r.min_y       <= cfg_data;
        qrp_pkg::REG_MIN_Z:  cfg_r.min_z       <= cfg_data;
        qrp_pkg::REG_MAX_X:  cfg_r.max_x       <= cfg_data;
        qrp_pkg::REG_MAX_Y:  cfg_r.max_y       <= cfg_data;
        qrp_pkg::REG_MAX_Z:  cfg_r.max_z       <= cfg_data;
        qrp_pkg::REG_SCALE:  cfg_r.scale_upper <= cfg_data[30:0];
        qrp_pkg::REG_WIDTHS: cfg_r.widths      <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // whole pipe moves unless the last stage holds an item the serializer can't take
  assign adv       = !div_valid || take;
  assign in_tready = adv;

  qrp_front #(
    .MAX_QUANT_BITS (MAX_QUANT_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid && (in_tuser != qrp_pkg::OP_NONE)),
    .in_op     (in_tuser),
    .in_raw    (in_tdata[63:0]),
    .in_sample (in_tdata[95:64]),
    .cfg       (cfg_r),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_num   (f_num),
    .out_den   (f_den)
  );

  qrp_div #(
    .QB (QB)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_num    (f_num),
    .in_den    (f_den),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_q     (div_q)
  );

  always_comb begin
    case (div_side.sel)
      qrp_pkg::SEL_RAW:  value_c = div_side.raw;
      qrp_pkg::SEL_ZERO: value_c = '0;
      qrp_pkg::SEL_MAX:  value_c = 64'(div_side.maxcode);
      qrp_pkg::SEL_DIV:  value_c = 64'(div_q);
      default:           value_c = '0;
    endcase
  end

  qrp_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (div_valid),
    .in_value   (value_c),
    .in_nbytes  (div_side.nbytes),
    .take       (take),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `QRP_ASSERT(a_code_range, clk, rst_n, div_valid && (div_side.sel == qrp_pkg::SEL_DIV) |-> 32'(div_q) <= 32'(div_side.maxcode), "quantized code above maxcode")
  `QRP_ASSERT(a_stall_holds, clk, rst_n, div_valid && !adv |=> div_valid, "item lost in stall")
  `QRP_ASSERT(a_field_runs, clk, rst_n, out_tvalid && out_tready && !out_tlast |=> out_tvalid, "field bytes broken off")
endmodule

// File: tb/quantizing_record_packer_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantizing record packer checker
// Watches the input, config and output channels. It predicts the bytes of
// every accepted field and compares each output item against the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module quantizing_record_packer_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_bytes,
  output int          bytes_seen
);
  localparam longint FIX_ONE = 64'sd65536;

  logic [31:0] bounds_lo [3];
  logic [31:0] bounds_hi [3];
  logic [30:0] scale_hi;
  logic [14:0] widths;
  logic [8:0]  byte_queue [$];

  function automatic logic [15:0] min_max_code(longint v, longint lo, longint hi,
                                               longint maxcode);
    longint d;
    longint r;
    d = v - lo;
    r = hi - lo;
    if (r <= 0) r = FIX_ONE;
    if (d <= 0) return 16'd0;
    if (d >= r) return maxcode[15:0];
    return 16'((d * maxcode * 2 + r) / (r * 2));
  endfunction

  function automatic logic [15:0] code_for_width(longint v, longint lo, longint hi,
                                                 logic [4:0] bits);
    if (bits == 0 || bits > 16) return 16'd0;
    return min_max_code(v, lo, hi, (longint'(1) << bits) - 1);
  endfunction

  task automatic queue_field(logic [63:0] value, int nbytes);
    for (int k = 0; k < nbytes; k++)
      byte_queue.insert(byte_queue.size(), {k == nbytes - 1, value[8*k +: 8]});
  endtask

  task automatic predict_field(logic [3:0] op, logic [63:0] raw, logic [31:0] sample);
    longint v;
    logic [1:0] axis;
    v = longint'($signed(sample));
    case (op)
      qrp_pkg::OP_ID, qrp_pkg::OP_PRIO, qrp_pkg::OP_SEQ: queue_field(raw, 4);
      qrp_pkg::OP_HOST:                                  queue_field(raw, 8);
      qrp_pkg::OP_COUNT, qrp_pkg::OP_FLAGS:              queue_field(raw, 2);
      qrp_pkg::OP_POS_X, qrp_pkg::OP_POS_Y, qrp_pkg::OP_POS_Z: begin
        axis = 2'(op - qrp_pkg::OP_POS_X);
        queue_field(64'(code_for_width(v, longint'($signed(bounds_lo[axis])),
                    longint'($signed(bounds_hi[axis])), widths[4:0])), 2);
      end
      qrp_pkg::OP_SCL_X, qrp_pkg::OP_SCL_Y, qrp_pkg::OP_SCL_Z:
        queue_field(64'(code_for_width(v, 0, longint'(scale_hi), widths[9:5])), 2);
      qrp_pkg::OP_OPAC: queue_field(64'(min_max_code(v, 0, FIX_ONE, 255)), 1);
      qrp_pkg::OP_UNC:  queue_field(64'(code_for_width(v, 0, FIX_ONE, widths[14:10])), 2);
      qrp_pkg::OP_COEF:
        queue_field(64'(min_max_code(v, -4 * FIX_ONE, 4 * FIX_ONE, 255)), 1);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    logic [8:0] want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        bounds_lo[i] <= 32'd0;
        bounds_hi[i] <= 32'h0001_0000;
      end
      scale_hi      <= 31'h0001_0000;
      widths        <= 15'd12816;
      fail_count    <= 0;
      pending_bytes <= 0;
      bytes_seen    <= 0;
      byte_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          qrp_pkg::REG_MIN_X, qrp_pkg::REG_MIN_Y, qrp_pkg::REG_MIN_Z:
            bounds_lo[cfg_index[1:0]] <= cfg_data;
          qrp_pkg::REG_MAX_X, qrp_pkg::REG_MAX_Y, qrp_pkg::REG_MAX_Z:
            bounds_hi[2'(cfg_index - qrp_pkg::REG_MAX_X)] <= cfg_data;
          qrp_pkg::REG_SCALE:  scale_hi <= cfg_data[30:0];
          qrp_pkg::REG_WIDTHS: widths <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        bytes_seen <= bytes_seen + 1;
        if (byte_queue.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected item byte=%02h last=%0b", out_tdata, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = byte_queue.pop_front();
          if (want != {out_tlast, out_tdata}) begin
            if (fail_count < 10)
              $display("ERROR: byte exp %02h last %0b, got %02h last %0b",
                       want[7:0], want[8], out_tdata, out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_field(in_tuser, in_tdata[63:0], in_tdata[95:64]);
      pending_bytes <= byte_queue.size();
    end
  end
endmodule

// File: tb/quantizing_record_packer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantizing record packer testbench
// Drives directed and random record fields under several bound and width
// settings, with random gaps on both sides; the checker judges the bytes.
// ----------------------------------------------------------------------------
module quantizing_record_packer_unit_tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_bytes;
  int          bytes_seen;
  int          idle_cycles;
  int          fields_sent;
  int          cfg_writes;
  bit          stall_enable;

  quantizing_record_packer_unit dut (.*);

  quantizing_record_packer_unit_checker checker_inst (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || !stall_enable) out_tready <= 1'b1;
    else out_tready <= (gap_len() == 0);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d bytes pending", pending_bytes);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_field(logic [3:0] op, logic [63:0] raw, logic [31:0] sample);
    int gap;
    gap = stall_enable ? gap_len() : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {sample, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fields_sent++;
  endtask

  task automatic write_reg(logic [7:0] index, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(5))
      0: return $urandom();
      1: return lo + $urandom_range(3) - 1;
      2: return hi + $urandom_range(3) - 1;
      default: return lo + (($signed(hi) > $signed(lo)) ? $urandom_range(hi - lo) : 0);
    endcase
  endfunction

  task automatic random_fields(int count, logic [31:0] lo, logic [31:0] hi);
    logic [3:0] op;
    for (int n = 0; n < count; n++) begin
      op = 4'($urandom_range(15));
      if (op == qrp_pkg::OP_NONE && $urandom_range(3) != 0) op = qrp_pkg::OP_POS_X;
      send_field(op, {$urandom(), $urandom()}, pick_sample(lo, hi));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = qrp_pkg::OP_NONE;
    cfg_valid    = 1'b0;
    cfg_index    = qrp_pkg::REG_MIN_X;
    cfg_data     = '0;
    stall_enable = 1'b0;
    fields_sent  = 0;
    cfg_writes   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration
    send_field(qrp_pkg::OP_ID, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_field(qrp_pkg::OP_HOST, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF);
    send_field(qrp_pkg::OP_HOST, 64'h0, 32'h0);
    send_field(qrp_pkg::OP_COUNT, 64'hAAAA_5555, 32'h0);
    send_field(qrp_pkg::OP_FLAGS, 64'h5555_AAAA, 32'h0);
    send_field(qrp_pkg::OP_PRIO, 64'hDEAD_BEEF, 32'h0);
    send_field(qrp_pkg::OP_SEQ, 64'hCAFE_F00D, 32'h0);
    send_field(qrp_pkg::OP_POS_X, 64'h0, 32'h0000_8000);
    send_field(qrp_pkg::OP_POS_Y, 64'h0, 32'h8000_0000);
    send_field(qrp_pkg::OP_POS_Z, 64'h0, 32'h7FFF_FFFF);
    send_field(qrp_pkg::OP_SCL_X, 64'h0, 32'h0000_4000);
    send_field(qrp_pkg::OP_SCL_Y, 64'h0, 32'h0001_0000);
    send_field(qrp_pkg::OP_SCL_Z, 64'h0, 32'hFFFF_FFFF);
    send_field(qrp_pkg::OP_OPAC, 64'h0, 32'h0000_0080);
    send_field(qrp_pkg::OP_OPAC, 64'h0, 32'h0001_0001);
    send_field(qrp_pkg::OP_UNC, 64'h0, 32'h0000_0008);
    send_field(qrp_pkg::OP_COEF, 64'h0, 32'hFFFC_0000);
    send_field(qrp_pkg::OP_COEF, 64'h0, 32'h0000_0000);
    send_field(qrp_pkg::OP_COEF, 64'h0, 32'h0004_0000);
    send_field(qrp_pkg::OP_NONE, 64'hFFFF, 32'h1234);
    wait_drained();

    // inverted/empty ranges, bad widths
    write_reg(qrp_pkg::REG_MIN_X, 32'h0002_0000);
    write_reg(qrp_pkg::REG_MAX_X, 32'h0001_0000);
    write_reg(qrp_pkg::REG_MIN_Y, 32'h0000_5000);
    write_reg(qrp_pkg::REG_MAX_Y, 32'h0000_5000);
    write_reg(qrp_pkg::REG_SCALE, 32'h0);
    write_reg(qrp_pkg::REG_WIDTHS, {17'd0, 5'd0, 5'd17, 5'd31});
    write_reg(8'd9, 32'hFFFF_FFFF);
    send_field(qrp_pkg::OP_POS_X, 64'h0, 32'h0002_8000);
    send_field(qrp_pkg::OP_POS_Y, 64'h0, 32'h0000_D000);
    send_field(qrp_pkg::OP_SCL_X, 64'h0, 32'h0000_1000);
    send_field(qrp_pkg::OP_UNC, 64'h0, 32'h0000_8000);
    wait_drained();

    stall_enable = 1'b1;
    random_fields(110, 32'h0, 32'h0001_0000);
    wait_drained();

    // full-scale signed bounds, max widths
    write_reg(qrp_pkg::REG_MIN_X, 32'h8000_0000);
    write_reg(qrp_pkg::REG_MAX_X, 32'h7FFF_FFFF);
    write_reg(qrp_pkg::REG_MIN_Y, 32'h8000_0000);
    write_reg(qrp_pkg::REG_MAX_Y, 32'h7FFF_FFFF);
    write_reg(qrp_pkg::REG_MIN_Z, 32'h8000_0000);
    write_reg(qrp_pkg::REG_MAX_Z, 32'h7FFF_FFFF);
    write_reg(qrp_pkg::REG_SCALE, 32'h7FFF_FFFF);
    write_reg(qrp_pkg::REG_WIDTHS, 32'h0000_7FFF);
    random_fields(110, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();

    write_reg(qrp_pkg::REG_WIDTHS, {17'd0, 5'd16, 5'd16, 5'd16});
    random_fields(110, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();

    // small random ranges and widths
    for (int p = 0; p < 3; p++) begin
      logic [31:0] lo;
      lo = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      write_reg(qrp_pkg::REG_MIN_X, lo);
      write_reg(qrp_pkg::REG_MIN_Y, lo);
      write_reg(qrp_pkg::REG_MIN_Z, lo);
      write_reg(qrp_pkg::REG_MAX_X, lo + $urandom_range(32'h0003_0000, 1));
      write_reg(qrp_pkg::REG_MAX_Y, lo + $urandom_range(32'h0000_0100, 1));
      write_reg(qrp_pkg::REG_MAX_Z, lo + $urandom_range(32'h0008_0000, 1));
      write_reg(qrp_pkg::REG_SCALE, $urandom_range(32'h0004_0000, 1));
      write_reg(qrp_pkg::REG_WIDTHS, {17'd0, 5'($urandom_range(16, 1)),
                                      5'($urandom_range(16, 1)),
                                      5'($urandom_range(16, 1))});
      random_fields(45, lo, lo + 32'h0002_0000);
      wait_drained();
    end

    $display("Sent %0d fields with %0d register writes; %0d bytes checked.",
             fields_sent, cfg_writes, bytes_seen);
    $display("Covered raw pass-through, all quantized kinds, clamps, bad widths, flat ranges.");
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
